@@ rtl/fsa_pkg.sv @@
package fsa_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int OP_W        = 5;
    localparam int LIMIT_W     = 6;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(30);

    localparam logic [OP_W-1:0] OP_PUSH   = 5'd0;
    localparam logic [OP_W-1:0] OP_POP    = 5'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 5'd2;
    localparam logic [OP_W-1:0] OP_DUP    = 5'd3;
    localparam logic [OP_W-1:0] OP_SWAP   = 5'd4;
    localparam logic [OP_W-1:0] OP_OVER   = 5'd5;
    localparam logic [OP_W-1:0] OP_ROT    = 5'd6;
    localparam logic [OP_W-1:0] OP_DROP   = 5'd7;
    localparam logic [OP_W-1:0] OP_2SWAP  = 5'd8;
    localparam logic [OP_W-1:0] OP_2DUP   = 5'd9;
    localparam logic [OP_W-1:0] OP_2OVER  = 5'd10;
    localparam logic [OP_W-1:0] OP_2DROP  = 5'd11;
    localparam logic [OP_W-1:0] OP_ADD    = 5'd12;
    localparam logic [OP_W-1:0] OP_SUB    = 5'd13;
    localparam logic [OP_W-1:0] OP_MUL    = 5'd14;
    localparam logic [OP_W-1:0] OP_DIV    = 5'd15;
    localparam logic [OP_W-1:0] OP_MOD    = 5'd16;
    localparam logic [OP_W-1:0] OP_DIVMOD = 5'd17;
    localparam logic [OP_W-1:0] OP_LT     = 5'd18;
    localparam logic [OP_W-1:0] OP_EQ     = 5'd19;
    localparam logic [OP_W-1:0] OP_GT     = 5'd20;
    localparam logic [OP_W-1:0] OP_LE     = 5'd21;
    localparam logic [OP_W-1:0] OP_GE     = 5'd22;

    // controller to datapath
    typedef struct packed {
        logic       latch;
        logic [2:0] rd_k;
        logic       cap_en;
        logic [1:0] cap_k;
        logic       div_start;
        logic       wr_en;
        logic [1:0] wr_j;
        logic       finish;
    } fsa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       div_need;
        logic       div_done;
        logic [2:0] nw;
        logic       out_busy;
    } fsa_status_t;

    // operands a word needs on the stack
    function automatic logic [2:0] fsa_need(input logic [OP_W-1:0] op);
        logic [2:0] n;
        case (op)
            OP_PUSH:                   n = 3'd0;
            OP_POP, OP_PEEK, OP_DUP,
            OP_DROP:                   n = 3'd1;
            OP_ROT:                    n = 3'd3;
            OP_2SWAP, OP_2OVER:        n = 3'd4;
            default:                   n = 3'd2;
        endcase
        return n;
    endfunction

    // entries a word adds when it succeeds (only growth matters for the limit)
    function automatic logic [1:0] fsa_grow(input logic [OP_W-1:0] op);
        logic [1:0] g;
        case (op)
            OP_PUSH, OP_DUP, OP_OVER: g = 2'd1;
            OP_2DUP, OP_2OVER:        g = 2'd2;
            default:                  g = 2'd0;
        endcase
        return g;
    endfunction

endpackage

@@ rtl/fsa_ram.sv @@
module fsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/fsa_div.sv @@
module fsa_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);
    import fsa_pkg::*;

    logic [32:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        shifted   = {rem_reg[31:0], quo_reg[31]};
        diff      = shifted - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_next = diff;
            end
            else
            begin
                rem_next = shifted;
            end
            quo_next = {quo_reg[30:0], ~diff[32]};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[31:0];
endmodule

@@ rtl/fsa_ctrl.sv @@
module fsa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    output logic                 in_ready,
    input  fsa_pkg::fsa_status_t status,
    output fsa_pkg::fsa_cmd_t    cmd
);
    import fsa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIVGO,
        S_DIVWAIT,
        S_WRITE,
        S_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_fire;
                if (in_fire)
                begin
                    state_next = S_READ;
                    cnt_next   = '0;
                end
            end
            S_READ:
            begin
                cmd.rd_k   = cnt_reg;
                cmd.cap_en = (cnt_reg != 3'd0);
                cmd.cap_k  = 2'(cnt_reg - 3'd1);
                cnt_next   = cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    state_next = S_DIVGO;
                end
            end
            S_DIVGO:
            begin
                cnt_next = '0;
                if (status.div_need)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVWAIT;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_DIVWAIT:
            begin
                if (status.div_done)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.wr_j = cnt_reg[1:0];
                if (cnt_reg < status.nw)
                begin
                    cmd.wr_en = 1'b1;
                    cnt_next  = cnt_reg + 3'd1;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end
endmodule

@@ rtl/fsa_datapath.sv @@
module fsa_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fsa_pkg::fsa_cmd_t    cmd,
    output fsa_pkg::fsa_status_t status,
    input  logic [4:0]           operation,
    input  logic [31:0]          push_value,
    input  logic                 cfg_we,
    input  logic [5:0]           cfg_wdata,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic                 ok,
    output logic [31:0]          result_value,
    output logic [5:0]           depth
);
    import fsa_pkg::*;

    logic [OP_W-1:0]    op_reg;
    logic [DATA_W-1:0]  pv_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [DATA_W-1:0]  t_reg [4];
    logic               out_valid_reg;
    logic               ok_reg;
    logic [DATA_W-1:0]  val_reg;
    logic [DEPTH_W-1:0] odepth_reg;

    logic [DATA_W-1:0]  rdata;
    logic [ADDR_W-1:0]  raddr;
    logic [ADDR_W-1:0]  waddr;

    logic [LIMIT_W-1:0] lim_eff;
    logic [2:0]         need;
    logic [1:0]         grow;
    logic               legal;
    logic               is_div;
    logic               div_done;
    logic [DATA_W-1:0]  uq, ur, ua, ub, q_s, r_s;
    logic               na, nb;
    logic [DATA_W-1:0]  prod;

    logic               ok_c;
    logic [DEPTH_W-1:0] nd;
    logic [2:0]         nw;
    logic [DATA_W-1:0]  w [4];
    logic [DATA_W-1:0]  val_c;
    logic [DEPTH_W-1:0] base;

    fsa_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STACK_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (cmd.wr_en),
        .waddr(waddr),
        .wdata(w[cmd.wr_j]),
        .raddr(raddr),
        .rdata(rdata)
    );

    // divider sees magnitudes; signs are fixed up afterwards
    assign na = t_reg[1][DATA_W-1];
    assign nb = t_reg[0][DATA_W-1];
    assign ua = na ? (DATA_W'(0) - t_reg[1]) : t_reg[1];
    assign ub = nb ? (DATA_W'(0) - t_reg[0]) : t_reg[0];

    fsa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (ua),
        .divisor  (ub),
        .done     (div_done),
        .quotient (uq),
        .remainder(ur)
    );

    assign q_s = (na != nb) ? (DATA_W'(0) - uq) : uq;
    assign r_s = na ? (DATA_W'(0) - ur) : ur;
    assign prod = DATA_W'(t_reg[1] * t_reg[0]);

    assign raddr = ADDR_W'(depth_reg - DEPTH_W'(1) - DEPTH_W'(cmd.rd_k));
    assign base  = DEPTH_W'(nd - DEPTH_W'(nw));
    assign waddr = ADDR_W'(base + DEPTH_W'(cmd.wr_j));

    assign lim_eff = (limit_reg > LIMIT_W'(STACK_DEPTH)) ? LIMIT_W'(STACK_DEPTH) : limit_reg;
    assign need    = fsa_need(op_reg);
    assign grow    = fsa_grow(op_reg);
    assign legal   = (op_reg <= OP_GE)
                   && ({1'b0, depth_reg} >= 7'(need))
                   && !((grow != 2'd0)
                        && (({1'b0, depth_reg} + 7'(grow)) > 7'(lim_eff)));
    assign is_div  = (op_reg == OP_DIV) || (op_reg == OP_MOD) || (op_reg == OP_DIVMOD);

    // new stack image: nd entries, the top nw of them rewritten from w
    always_comb
    begin
        ok_c = legal;
        nd   = depth_reg;
        nw   = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            w[i] = '0;
        end
        if (legal)
        begin
            case (op_reg)
                OP_PUSH:  begin nd = depth_reg + 6'd1; nw = 3'd1; w[0] = pv_reg; end
                OP_POP:   begin nd = depth_reg - 6'd1; end
                OP_PEEK:  begin nd = depth_reg; end
                OP_DUP:   begin nd = depth_reg + 6'd1; nw = 3'd1; w[0] = t_reg[0]; end
                OP_SWAP:
                begin
                    nw = 3'd2; w[0] = t_reg[0]; w[1] = t_reg[1];
                end
                OP_OVER:  begin nd = depth_reg + 6'd1; nw = 3'd1; w[0] = t_reg[1]; end
                OP_ROT:
                begin
                    nw = 3'd3; w[0] = t_reg[1]; w[1] = t_reg[0]; w[2] = t_reg[2];
                end
                OP_DROP:  begin nd = depth_reg - 6'd1; end
                OP_2SWAP:
                begin
                    nw = 3'd4;
                    w[0] = t_reg[1]; w[1] = t_reg[0]; w[2] = t_reg[3]; w[3] = t_reg[2];
                end
                OP_2DUP:
                begin
                    nd = depth_reg + 6'd2; nw = 3'd2; w[0] = t_reg[1]; w[1] = t_reg[0];
                end
                OP_2OVER:
                begin
                    nd = depth_reg + 6'd2; nw = 3'd2; w[0] = t_reg[3]; w[1] = t_reg[2];
                end
                OP_2DROP: begin nd = depth_reg - 6'd2; end
                OP_DIV, OP_MOD, OP_DIVMOD:
                begin
                    if (t_reg[0] == '0)
                    begin
                        ok_c = 1'b0;
                        nd   = depth_reg - 6'd2;
                    end
                    else if (op_reg == OP_DIVMOD)
                    begin
                        nw = 3'd2; w[0] = r_s; w[1] = q_s;
                    end
                    else
                    begin
                        nd = depth_reg - 6'd1; nw = 3'd1;
                        w[0] = (op_reg == OP_DIV) ? q_s : r_s;
                    end
                end
                default:
                begin
                    nd = depth_reg - 6'd1;
                    nw = 3'd1;
                    case (op_reg)
                        OP_ADD: w[0] = t_reg[1] + t_reg[0];
                        OP_SUB: w[0] = t_reg[1] - t_reg[0];
                        OP_MUL: w[0] = prod;
                        OP_LT:  w[0] = DATA_W'($signed(t_reg[1]) < $signed(t_reg[0]));
                        OP_EQ:  w[0] = DATA_W'(t_reg[1] == t_reg[0]);
                        OP_GT:  w[0] = DATA_W'($signed(t_reg[1]) > $signed(t_reg[0]));
                        OP_LE:  w[0] = DATA_W'($signed(t_reg[1]) <= $signed(t_reg[0]));
                        default: w[0] = DATA_W'($signed(t_reg[1]) >= $signed(t_reg[0]));
                    endcase
                end
            endcase
        end
    end

    always_comb
    begin
        if (ok_c && (op_reg == OP_POP))
        begin
            val_c = t_reg[0];
        end
        else if (nd == '0)
        begin
            val_c = '0;
        end
        else if (nw != 3'd0)
        begin
            val_c = w[2'(nw - 3'd1)];
        end
        else
        begin
            val_c = t_reg[2'(depth_reg - nd)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.finish)
            begin
                depth_reg     <= nd;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg <= operation;
            pv_reg <= push_value;
        end
        if (cmd.cap_en)
        begin
            t_reg[cmd.cap_k] <= rdata;
        end
        if (cmd.finish)
        begin
            ok_reg     <= ok_c;
            val_reg    <= val_c;
            odepth_reg <= nd;
        end
    end

    assign status.div_need = legal && is_div && (t_reg[0] != '0);
    assign status.div_done = div_done;
    assign status.nw       = nw;
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid    = out_valid_reg;
    assign ok           = ok_reg;
    assign result_value = val_reg;
    assign depth        = odepth_reg;
endmodule

@@ rtl/forth_data_stack_alu_core.sv @@
// Forth data stack with a 32-bit integer ALU.
// Slave stream: one word per Forth operation; tuser carries the operation
// code, tdata the value used by push. Master stream: one word per operation
// with the success flag in tuser and the result value and the depth after
// the operation in tdata.
// cfg_we/cfg_wdata write stack_limit (reset 30); write it only while idle.
// Each operation is run by a sequencer: accept, a fetch of the top four
// entries from the stack RAM, a step to start the divider or skip it, a
// write-back of each rewritten entry, the exit from write-back, and the
// load of the output register. div, mod and divmod with a nonzero divisor
// also wait for the bit-serial divider before the write-back.
// One operation is in flight at a time; a new word is taken once the last
// one has left the sequencer, even if its result still waits in the output
// register. When the receiver stalls, the result is held and the next
// operation stops at its final step until the output register is free.
// Reset empties the stack (depth 0) and restores the limit; the stack RAM
// itself is not cleared, since only entries below the depth are ever used.
module forth_data_stack_alu_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] push_value
    input  logic [7:0]  s_axis_tuser,   // [4:0] operation, rest zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] result_value, [37:32] depth, rest zero
    output logic [7:0]  m_axis_tuser,   // [0] ok, rest zero
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata
);
    import fsa_pkg::*;

    fsa_cmd_t    cmd;
    fsa_status_t status;
    logic        in_ready;
    logic        in_fire;
    logic        ok;
    logic [31:0] result_value;
    logic [5:0]  depth;

    // a word enters when the sequencer is free
    assign s_axis_tready = in_ready;
    assign in_fire       = s_axis_tvalid && in_ready;

    fsa_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .in_ready(in_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fsa_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .operation   (s_axis_tuser[4:0]),
        .push_value  (s_axis_tdata),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .ok          (ok),
        .result_value(result_value),
        .depth       (depth)
    );

    // pack the result word
    assign m_axis_tdata = {2'b00, depth, result_value};
    assign m_axis_tuser = {7'd0, ok};
endmodule
